>>> hdl/bdq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and constants of the bounded deque
// Opcodes, status codes, controller states and the command and status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DATA_W           = 32;
    localparam int OP_W             = 3;
    localparam int POS_W            = 5;
    localparam int DEFAULT_CAPACITY = 16;
    localparam int DUMP_LIMIT       = 16;

    typedef enum logic [OP_W-1:0] {
        OP_DUMP       = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_PUSH_BACK  = 3'd2,
        OP_INSERT     = 3'd3,
        OP_POP_FRONT  = 3'd4,
        OP_POP_BACK   = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_DUMP,
        S_SH_RD,
        S_SH_WR,
        S_PLACE
    } state_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_FRONT,
        WR_BACK,
        WR_SHIFT,
        WR_PLACE
    } wr_sel_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_FRONT,
        RD_BACK,
        RD_DUMP_FIRST,
        RD_DUMP_NEXT,
        RD_SHIFT
    } rd_sel_t;

    typedef struct packed {
        wr_sel_t wr_sel;
        rd_sel_t rd_sel;
        logic    ld_shift;
        logic    emit;
        logic    emit_rdata;
        status_t emit_status;
        logic    emit_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_empty;
        logic is_full;
        logic pos_bad;
        logic pos_one;
        logic shift_done;
        logic dump_last;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

>>> hdl/bounded_deque_with_positional_insert.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque_with_positional_insert: double-ended queue with insert
// Holds up to CAPACITY signed 32-bit values, front first, and performs one
// operation per input transfer: dump, push front or back, insert at a
// one-based position, pop front or back.
//
// Input channel (in_valid / in_stall) carries opcode, value and position.
// Output channel (out_valid / out_stall) carries data_out, status and last;
// last marks the final result of an operation.
// Every push, failed operation and successful insert at position one gives
// its result in the cycle after the transfer, and a new item may follow in the
// next cycle. Pops read the memory first and then give the result. A dump
// reads its first value, then gives one value per cycle while the receiver
// does not stall, up to sixteen of them. An insert at position p into a list
// of n values moves n-p+1 values one at a time through the single memory
// port, each read in S_SH_RD and written in S_SH_WR, then places the value.
// Reset empties the list at once; the storage itself is not cleared.
// When the receiver stalls, the result register holds its transfer and the
// block stops taking input until that register can be reloaded.
// ----------------------------------------------------------------------------
module bounded_deque_with_positional_insert #(
    parameter int CAPACITY = bdq_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [bdq_pkg::OP_W-1:0]          opcode,
    input  wire logic signed [bdq_pkg::DATA_W-1:0] value,
    input  wire logic [bdq_pkg::POS_W-1:0]         position,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [bdq_pkg::DATA_W-1:0]      data_out,
    output logic [1:0]                             status,
    output logic                                   last
);
    import bdq_pkg::*;

    ctrl_cmd_t         cmd;
    dp_status_t        sts;
    logic [DATA_W-1:0] data_out_raw;

    // The controller decides every step; the datapath only obeys commands.
    bdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // Circular buffer, pointers and the result register.
    bdq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value     (value),
        .position  (position),
        .out_stall (out_stall),
        .sts       (sts),
        .out_valid (out_valid),
        .data_out  (data_out_raw),
        .status    (status),
        .last      (last)
    );

    assign data_out = $signed(data_out_raw);

    // A result is loaded only when the result register is free to take it.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> sts.out_free)
        else $error("result loaded over a pending transfer");

    // The single memory port is never asked to read and write together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !((cmd.wr_sel != WR_NONE) && (cmd.rd_sel != RD_NONE)))
        else $error("memory read and write issued in the same cycle");

    // After a result that is not the last of its operation, input stays closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !cmd.emit_last) |=> in_stall)
        else $error("input opened in the middle of a dump");

endmodule
`default_nettype wire

>>> hdl/bdq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ctrl: operation sequencer of the bounded deque
// Decodes each accepted item and steps the datapath through reads, shifts
// and result transfers.
// ----------------------------------------------------------------------------
module bdq_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic [bdq_pkg::OP_W-1:0] opcode,
    input  wire bdq_pkg::dp_status_t      sts,
    output bdq_pkg::ctrl_cmd_t            cmd,
    output logic                          in_stall
);
    import bdq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   take;

    assign in_stall = !((state_reg == S_IDLE) && sts.out_free);
    assign take     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    case (opcode)
                        OP_DUMP:
                        begin
                            if (!sts.is_empty)
                            begin
                                state_next = S_DUMP;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (!sts.pos_bad && !sts.is_full && !sts.pos_one)
                            begin
                                state_next = S_SH_RD;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (!sts.is_empty)
                            begin
                                state_next = S_POP;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (sts.out_free && sts.dump_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SH_RD:
            begin
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                state_next = sts.shift_done ? S_PLACE : S_SH_RD;
            end
            S_PLACE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd             = '0;
        cmd.wr_sel      = WR_NONE;
        cmd.rd_sel      = RD_NONE;
        cmd.emit_status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    case (opcode)
                        OP_DUMP:
                        begin
                            if (sts.is_empty)
                            begin
                                cmd.emit_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.emit   = 1'b0;
                                cmd.rd_sel = RD_DUMP_FIRST;
                            end
                        end
                        OP_PUSH_FRONT:
                        begin
                            if (sts.is_full)
                            begin
                                cmd.emit_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.wr_sel = WR_FRONT;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (sts.is_full)
                            begin
                                cmd.emit_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.wr_sel = WR_BACK;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (sts.pos_bad)
                            begin
                                cmd.emit_status = ST_INVALID;
                            end
                            else if (sts.is_full)
                            begin
                                cmd.emit_status = ST_FULL;
                            end
                            else if (sts.pos_one)
                            begin
                                cmd.wr_sel = WR_FRONT;
                            end
                            else
                            begin
                                cmd.emit     = 1'b0;
                                cmd.ld_shift = 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (sts.is_empty)
                            begin
                                cmd.emit_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.emit   = 1'b0;
                                cmd.rd_sel = RD_FRONT;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (sts.is_empty)
                            begin
                                cmd.emit_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.emit   = 1'b0;
                                cmd.rd_sel = RD_BACK;
                            end
                        end
                        default:
                        begin
                            cmd.emit_status = ST_INVALID;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                if (sts.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_rdata = 1'b1;
                    cmd.emit_last  = 1'b1;
                end
            end
            S_DUMP:
            begin
                if (sts.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_rdata = 1'b1;
                    cmd.emit_last  = sts.dump_last;
                    if (!sts.dump_last)
                    begin
                        cmd.rd_sel = RD_DUMP_NEXT;
                    end
                end
            end
            S_SH_RD:
            begin
                cmd.rd_sel = RD_SHIFT;
            end
            S_SH_WR:
            begin
                cmd.wr_sel = WR_SHIFT;
            end
            S_PLACE:
            begin
                if (sts.out_free)
                begin
                    cmd.wr_sel    = WR_PLACE;
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                end
            end
            default:
            begin
                cmd.emit = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/bdq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_datapath: storage and result register of the bounded deque
// A circular buffer in a one-write, one-read memory with head pointer and
// fill count, a shift cursor and the registered result.
// ----------------------------------------------------------------------------
module bdq_datapath #(
    parameter int CAPACITY = bdq_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire bdq_pkg::ctrl_cmd_t         cmd,
    input  wire logic [bdq_pkg::DATA_W-1:0] value,
    input  wire logic [bdq_pkg::POS_W-1:0]  position,
    input  wire logic                       out_stall,
    output bdq_pkg::dp_status_t             sts,
    output logic                            out_valid,
    output logic [bdq_pkg::DATA_W-1:0]      data_out,
    output logic [1:0]                      status,
    output logic                            last
);
    import bdq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rdata_reg;
    logic [DATA_W-1:0] value_reg;
    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     head_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     k_reg;
    logic [CW-1:0]     k_next;
    logic [CW-1:0]     idx_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] data_out_reg;
    logic [1:0]        status_reg;
    logic              last_reg;

    logic [CW-1:0]     rd_off;
    logic [CW-1:0]     wr_off;
    logic [CW:0]       rd_sum;
    logic [CW:0]       wr_sum;
    logic [CW:0]       rd_wrap;
    logic [CW:0]       wr_wrap;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [PW-1:0]     pos_ext;
    logic [PW-1:0]     pos_m1;
    logic [CW-1:0]     dump_n;

    // Logical offset from the head for each access.
    always_comb
    begin
        case (cmd.rd_sel)
            RD_BACK:      rd_off = count_reg - CW'(1);
            RD_DUMP_NEXT: rd_off = k_reg + CW'(1);
            RD_SHIFT:     rd_off = k_reg - CW'(1);
            default:      rd_off = '0;
        endcase
        case (cmd.wr_sel)
            WR_FRONT: wr_off = CW'(CAPACITY - 1);
            WR_BACK:  wr_off = count_reg;
            WR_SHIFT: wr_off = k_reg;
            WR_PLACE: wr_off = idx_reg;
            default:  wr_off = '0;
        endcase
        case (cmd.wr_sel)
            WR_SHIFT: wr_data = rdata_reg;
            WR_PLACE: wr_data = value_reg;
            default:  wr_data = value;
        endcase
    end

    // Both sums stay below twice the capacity, so one subtraction wraps them.
    assign rd_sum  = (CW+1)'(head_reg) + (CW+1)'(rd_off);
    assign wr_sum  = (CW+1)'(head_reg) + (CW+1)'(wr_off);
    assign rd_wrap = (rd_sum >= (CW+1)'(CAPACITY)) ? rd_sum - (CW+1)'(CAPACITY) : rd_sum;
    assign wr_wrap = (wr_sum >= (CW+1)'(CAPACITY)) ? wr_sum - (CW+1)'(CAPACITY) : wr_sum;
    assign rd_addr = rd_wrap[AW-1:0];
    assign wr_addr = wr_wrap[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_sel != WR_NONE)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_sel != RD_NONE)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Pointer, count and cursor updates.
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        k_next     = k_reg;
        case (cmd.wr_sel)
            WR_FRONT:
            begin
                head_next  = wr_addr;
                count_next = count_reg + CW'(1);
            end
            WR_BACK, WR_PLACE:
            begin
                count_next = count_reg + CW'(1);
            end
            WR_SHIFT:
            begin
                k_next = k_reg - CW'(1);
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        case (cmd.rd_sel)
            RD_FRONT:
            begin
                head_next  = (head_reg == AW'(CAPACITY - 1)) ? '0 : head_reg + AW'(1);
                count_next = count_reg - CW'(1);
            end
            RD_BACK:
            begin
                count_next = count_reg - CW'(1);
            end
            RD_DUMP_FIRST:
            begin
                k_next = '0;
            end
            RD_DUMP_NEXT:
            begin
                k_next = k_reg + CW'(1);
            end
            default:
            begin
                k_next = k_next;
            end
        endcase
        if (cmd.ld_shift)
        begin
            k_next = count_reg;
        end
    end

    assign pos_ext = PW'(position);
    assign pos_m1  = pos_ext - PW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        if (cmd.ld_shift)
        begin
            idx_reg   <= pos_m1[CW-1:0];
            value_reg <= value;
        end
        if (cmd.emit)
        begin
            data_out_reg <= cmd.emit_rdata ? rdata_reg : '0;
            status_reg   <= cmd.emit_status;
            last_reg     <= cmd.emit_last;
        end
    end

    always_comb
    begin
        if ((CAPACITY > DUMP_LIMIT) && (count_reg > CW'(DUMP_LIMIT)))
        begin
            dump_n = CW'(DUMP_LIMIT);
        end
        else
        begin
            dump_n = count_reg;
        end
    end

    assign sts.is_empty   = (count_reg == '0);
    assign sts.is_full    = (count_reg == CW'(CAPACITY));
    assign sts.pos_bad    = (position == '0) || (pos_ext > PW'(count_reg));
    assign sts.pos_one    = (position == POS_W'(1));
    assign sts.shift_done = ((k_reg - CW'(1)) == idx_reg);
    assign sts.dump_last  = ((k_reg + CW'(1)) == dump_n);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule
`default_nettype wire

>>> dv/tb_bounded_deque_with_positional_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_positional_insert: self-checking bench for the deque
// Named tests drive operations through one shared send task. The first tests
// cover the empty list, both ends, positional insert and the full list. The
// last test sends weighted random traffic in fill, drain and mixed rounds.
// A shadow copy of the list predicts every result at the moment the input
// transfer is accepted. A separate process compares each output transfer,
// field by field, with the oldest prediction. Both channels idle at random,
// except for one long stretch with no idling.
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_positional_insert;

    import bdq_pkg::*;

    localparam int CAPACITY     = DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS = 240;
    // After the last prediction has been met, the block is given this many
    // further cycles to show any stray output transfer.
    localparam int DRAIN_CYCLES = 40;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int REPORT_LIMIT = 50;

    // Opcodes that the block does not define; both must answer invalid.
    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } mix_mode_t;

    // One expected output transfer.
    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        status_t                  st;
        logic                     last;
    } deque_result_t;

    // ------------------------------------------------------------------
    // Clock, reset and the signals of the block. Every input starts at a
    // known value before the first clock edge.
    // ------------------------------------------------------------------
    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic [OP_W-1:0]          opcode    = '0;
    logic signed [DATA_W-1:0] value     = '0;
    logic [POS_W-1:0]         position  = '0;
    logic                     out_stall = 1'b0;
    logic                     in_stall;
    logic                     out_valid;
    logic signed [DATA_W-1:0] data_out;
    logic [1:0]               status;
    logic                     last;

    // Shadow copy of the list, front at index zero.
    logic signed [DATA_W-1:0] deque_mem [0:CAPACITY-1];
    int                       deque_len = 0;

    // Results predicted but not yet seen on the output channel.
    deque_result_t pending_results [$];

    int mismatch_count = 0;
    // Percentages of cycles in which the sender idles and the receiver stalls.
    int idle_pct  = 23;
    int stall_pct = 23;

    initial forever #5 clk = ~clk;

    bounded_deque_with_positional_insert #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .value     (value),
        .position  (position),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .status    (status),
        .last      (last)
    );

    // ------------------------------------------------------------------
    // Mismatch reporting. Every mismatch is counted, but only the first
    // few are printed so that a badly broken block cannot flood the log.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // ------------------------------------------------------------------
    // Predictor. These tasks act on the shadow list and queue the results
    // that the block ought to produce for one accepted transfer.
    // ------------------------------------------------------------------
    task automatic expect_result(input logic signed [DATA_W-1:0] data,
                                 input status_t st, input logic is_last);
        deque_result_t r;
        r.data = data;
        r.st   = st;
        r.last = is_last;
        pending_results.push_back(r);
    endtask

    // Opens a gap at index idx and stores val there; the caller has made
    // sure that the list is not full.
    task automatic shift_in(input int idx, input logic signed [DATA_W-1:0] val);
        int k;
        for (k = deque_len; k > idx; k--)
        begin
            deque_mem[k] = deque_mem[k-1];
        end
        deque_mem[idx] = val;
        deque_len++;
    endtask

    task automatic predict_op(input logic [OP_W-1:0] op,
                              input logic signed [DATA_W-1:0] val,
                              input logic [POS_W-1:0] pos);
        int                       k;
        int                       n;
        logic signed [DATA_W-1:0] removed;
        case (op)
            OP_DUMP:
            begin
                if (deque_len == 0)
                begin
                    expect_result('0, ST_EMPTY, 1'b1);
                end
                else
                begin
                    // Only the first DUMP_LIMIT values are emitted, front first.
                    n = (deque_len < DUMP_LIMIT) ? deque_len : DUMP_LIMIT;
                    for (k = 0; k < n; k++)
                    begin
                        expect_result(deque_mem[k], ST_OK, k == n - 1);
                    end
                end
            end
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (deque_len >= CAPACITY)
                begin
                    expect_result('0, ST_FULL, 1'b1);
                end
                else
                begin
                    shift_in((op == OP_PUSH_FRONT) ? 0 : deque_len, val);
                    expect_result('0, ST_OK, 1'b1);
                end
            end
            OP_INSERT:
            begin
                // The position check wins over the full check, so an insert
                // into an empty list is always an invalid position.
                if (pos < 1 || pos > deque_len)
                begin
                    expect_result('0, ST_INVALID, 1'b1);
                end
                else if (deque_len >= CAPACITY)
                begin
                    expect_result('0, ST_FULL, 1'b1);
                end
                else
                begin
                    shift_in(int'(pos) - 1, val);
                    expect_result('0, ST_OK, 1'b1);
                end
            end
            OP_POP_FRONT:
            begin
                if (deque_len == 0)
                begin
                    expect_result('0, ST_EMPTY, 1'b1);
                end
                else
                begin
                    removed = deque_mem[0];
                    for (k = 0; k + 1 < deque_len; k++)
                    begin
                        deque_mem[k] = deque_mem[k+1];
                    end
                    deque_len--;
                    expect_result(removed, ST_OK, 1'b1);
                end
            end
            OP_POP_BACK:
            begin
                if (deque_len == 0)
                begin
                    expect_result('0, ST_EMPTY, 1'b1);
                end
                else
                begin
                    deque_len--;
                    expect_result(deque_mem[deque_len], ST_OK, 1'b1);
                end
            end
            default:
            begin
                expect_result('0, ST_INVALID, 1'b1);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Sender. The task is always entered at a rising edge. It may idle for
    // a few cycles with valid low, then presents the item and holds it
    // until the transfer is taken. Valid is left high on return, so that a
    // following item can go out in the very next cycle; it is lowered only
    // when an idle gap is chosen, which keeps to one assignment per step.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [OP_W-1:0] op,
                             input logic signed [DATA_W-1:0] val,
                             input logic [POS_W-1:0] pos);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        value    <= val;
        position <= pos;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        // The transfer is taken at this edge, so the expectation is queued
        // before any of its results can appear.
        predict_op(op, val, pos);
    endtask

    // ------------------------------------------------------------------
    // Receiver. The stall is redrawn at each edge. Output transfers are
    // sampled at the edge that accepts them, with the values that the
    // block itself sees there.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected transfer: data_out %0d status %0d last %0d",
                                          data_out, status, last));
            end
            else
            begin
                want = pending_results.pop_front();
                if (data_out !== want.data)
                begin
                    report_mismatch($sformatf("data_out %0d, expected %0d",
                                              data_out, want.data));
                end
                if (status !== want.st)
                begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, want.st));
                end
                if (last !== want.last)
                begin
                    report_mismatch($sformatf("last %0d, expected %0d", last, want.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Random helpers for the traffic test.
    // ------------------------------------------------------------------
    function automatic logic [OP_W-1:0] pick_opcode(input mix_mode_t mode);
        int roll;
        int push_w;
        int pop_w;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
            begin
                push_w = 75;
                pop_w  = 15;
            end
            MODE_DRAIN:
            begin
                push_w = 20;
                pop_w  = 70;
            end
            default:
            begin
                push_w = 45;
                pop_w  = 45;
            end
        endcase
        if (roll < push_w)
        begin
            case (roll % 3)
                0:       return OP_PUSH_FRONT;
                1:       return OP_PUSH_BACK;
                default: return OP_INSERT;
            endcase
        end
        else if (roll < push_w + pop_w)
        begin
            return (roll % 2 == 0) ? OP_POP_FRONT : OP_POP_BACK;
        end
        else if (roll < 98)
        begin
            return OP_DUMP;
        end
        return logic'($urandom_range(0, 1)) ? OP_UNUSED_7 : OP_UNUSED_6;
    endfunction

    // Mostly full-range random data, with the extremes now and then.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // Inserts mostly name a position that exists, so that the shifting path
    // is exercised; the rest spread over the whole field.
    function automatic logic [POS_W-1:0] pick_position(input logic [OP_W-1:0] op);
        if (op == OP_INSERT && $urandom_range(0, 99) < 75)
        begin
            return POS_W'($urandom_range(1, (deque_len > 0) ? deque_len : 1));
        end
        return POS_W'($urandom_range(0, (1 << POS_W) - 1));
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Every operation that can fail on an empty list.
    task automatic test_empty_list();
        send_item(OP_DUMP, '0, '0);
        send_item(OP_POP_FRONT, '0, '0);
        send_item(OP_POP_BACK, '0, '0);
        send_item(OP_INSERT, 32'sd5, 5'd1);
        send_item(OP_INSERT, 32'sd6, 5'd0);
    endtask

    // Both ends, the data extremes, insert at the edges of the valid range,
    // the undefined opcodes and a short dump.
    task automatic test_ends_and_insert();
        send_item(OP_PUSH_BACK, VAL_MAX, 5'd0);
        send_item(OP_PUSH_FRONT, VAL_MIN, 5'd31);
        // Position one behaves as a push at the front.
        send_item(OP_INSERT, 32'sh1234_5678, 5'd1);
        send_item(OP_INSERT, -1, 5'd3);
        send_item(OP_INSERT, 32'sd77, 5'd5);
        send_item(OP_INSERT, 32'sd78, 5'd31);
        send_item(OP_INSERT, 32'sd79, 5'd0);
        send_item(OP_UNUSED_6, 32'sd1, 5'd1);
        send_item(OP_UNUSED_7, -1, 5'd31);
        send_item(OP_DUMP, '0, '0);
        send_item(OP_POP_FRONT, '0, '0);
        send_item(OP_POP_BACK, '0, '0);
    endtask

    // Fill the list to capacity, then try every way of adding to it and
    // dump all of it.
    task automatic test_full_list();
        while (deque_len < CAPACITY)
        begin
            send_item(OP_PUSH_BACK, pick_value(), '0);
        end
        send_item(OP_PUSH_FRONT, 32'sd11, '0);
        send_item(OP_PUSH_BACK, 32'sd12, '0);
        send_item(OP_INSERT, 32'sd13, 5'd1);
        send_item(OP_INSERT, 32'sd14, 5'd16);
        // Beyond the count, so the position check answers before the full one.
        send_item(OP_INSERT, 32'sd15, 5'd17);
        send_item(OP_DUMP, '0, '0);
        send_item(OP_POP_FRONT, '0, '0);
        send_item(OP_INSERT, 32'sd16, 5'd15);
        send_item(OP_DUMP, '0, '0);
    endtask

    // Weighted random traffic in rounds that fill, drain or mix, so that the
    // list swings between empty and full many times. The first stretch runs
    // with no idling on either side.
    task automatic test_random_traffic();
        int        sent;
        int        round_len;
        int        k;
        mix_mode_t mode;
        logic [OP_W-1:0] op;
        sent      = 0;
        idle_pct  = 0;
        stall_pct = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= 70)
            begin
                idle_pct  = 23;
                stall_pct = 23;
            end
            mode      = mix_mode_t'($urandom_range(0, 2));
            round_len = $urandom_range(12, 40);
            for (k = 0; k < round_len && sent < RANDOM_ITEMS; k++)
            begin
                op = pick_opcode(mode);
                send_item(op, pick_value(), pick_position(op));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int waited;
        waited = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_empty_list();
        test_ends_and_insert();
        test_full_list();
        test_random_traffic();

        in_valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));
        end

        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // Guard against a hung handshake; far beyond the slowest correct run.
    initial
    begin
        #(3_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
